@@ design/b64d_pkg.sv @@
// Package for the base64 stream decoder: the queue entry type, the
// character constants and the alphabet lookup. No dependencies.
`default_nettype none

package b64d_pkg;

	localparam logic [7:0] PAD_CHAR  = 8'h3D;
	localparam logic [7:0] PLUS_CHAR = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	localparam logic [1:0] QUARTET_LAST = 2'd3;
	localparam logic [1:0] THIRD_POS    = 2'd2;

	localparam logic [1:0] COUNT_ONE   = 2'd1;
	localparam logic [1:0] COUNT_TWO   = 2'd2;
	localparam logic [1:0] COUNT_THREE = 2'd3;

	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  count;
		logic        fin;
		logic        err;
	} b64d_job_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] v;
		v = 6'd0;
		case (c) inside
			[8'h41:8'h5A]: v = 6'(c - 8'h41);
			[8'h61:8'h7A]: v = 6'(c - 8'h47);
			[8'h30:8'h39]: v = 6'(c + 8'h04);
			PLUS_CHAR:     v = 6'd62;
			SLASH_CHAR:    v = 6'd63;
			default:       v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ design/b64d_if.sv @@
// Channel interfaces for the base64 stream decoder: character input and
// byte output, each with valid/ready. No dependencies.
`default_nettype none

interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_final;

	modport source (output valid, output char_code, output is_final, input ready);
	modport sink (input valid, input char_code, input is_final, output ready);
endinterface

interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;
	logic       length_error;

	modport source (output valid, output data_byte, output end_of_data,
		output length_error, input ready);
	modport sink (input valid, input data_byte, input end_of_data,
		input length_error, output ready);
endinterface

`default_nettype wire

@@ design/base64_stream_decoder_core.sv @@
// Top level of the base64 stream decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
//
//   channel  dir  payload                                     handshake
//   in_ch    in   char_code[7:0], is_final                    valid/ready
//   out_ch   out  data_byte[7:0], end_of_data, length_error   valid/ready
//
// One character is taken per cycle while the queue has space; a finished
// quartet or a length error becomes one job. The back end sends one byte per
// cycle while out_ch.ready is high; a job's first byte passes the queue write,
// then the output load. Reset clears the quartet state, queue and busy flag.
// A stalled output fills the QUEUE_DEPTH-entry queue, then drops in_ch.ready.
`default_nettype none

module base64_stream_decoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b64d_in_if.sink    in_ch,
	b64d_out_if.source out_ch
);

	b64d_pkg::b64d_job_t push_job;
	b64d_pkg::b64d_job_t head_job;
	logic                push;
	logic                space;
	logic                head_valid;
	logic                pop;

	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.job    (push_job),
		.push   (push),
		.space  (space)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (push_job),
		.wr_en    (push),
		.space    (space),
		.rd_data  (head_job),
		.rd_valid (head_valid),
		.rd_en    (pop)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (head_valid),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

@@ design/b64d_front.sv @@
// Front end: accepts characters, collects quartets and pushes one job per
// quartet or length error into the queue. Depends on b64d_pkg, b64d_if.
`default_nettype none

module b64d_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	b64d_in_if.sink                 in_ch,
	output b64d_pkg::b64d_job_t     job,
	output logic                    push,
	input  wire logic               space
);

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic        third_pad_q;

	logic [5:0]  v;
	logic        is_pad;
	logic        accept;
	logic        pad_both;
	logic        pad_one;

	assign in_ch.ready = space;
	assign accept      = in_ch.valid && space;
	assign v           = b64d_pkg::sextet_of(in_ch.char_code);
	assign is_pad      = (in_ch.char_code == b64d_pkg::PAD_CHAR);
	assign push        = accept && ((pos_q == b64d_pkg::QUARTET_LAST) || in_ch.is_final);
	assign pad_both    = third_pad_q && is_pad;
	assign pad_one     = third_pad_q ^ is_pad;

	always_comb begin
		job.fin = in_ch.is_final;
		if (pos_q != b64d_pkg::QUARTET_LAST) begin
			job.word  = 24'd0;
			job.count = b64d_pkg::COUNT_ONE;
			job.err   = 1'b1;
		end else begin
			job.word = {acc_q, v};
			job.err  = 1'b0;
			if (!in_ch.is_final) begin
				job.count = b64d_pkg::COUNT_THREE;
			end else if (pad_both) begin
				job.count = b64d_pkg::COUNT_ONE;
			end else if (pad_one) begin
				job.count = b64d_pkg::COUNT_TWO;
			end else begin
				job.count = b64d_pkg::COUNT_THREE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= '0;
			third_pad_q <= 1'b0;
		end else if (accept) begin
			if (push) begin
				acc_q       <= '0;
				pos_q       <= '0;
				third_pad_q <= 1'b0;
			end else begin
				acc_q <= {acc_q[11:0], v};
				pos_q <= pos_q + 2'd1;
				if (pos_q == b64d_pkg::THIRD_POS) begin
					third_pad_q <= is_pad;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/b64d_queue.sv @@
// Short job queue between front and back end.
// Depends on b64d_pkg.
`default_nettype none

module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire b64d_pkg::b64d_job_t  wr_data,
	input  wire logic                 wr_en,
	output logic                      space,
	output b64d_pkg::b64d_job_t       rd_data,
	output logic                      rd_valid,
	input  wire logic                 rd_en
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64d_pkg::b64d_job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign space    = (cnt_q != FULL_CNT);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && space;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/b64d_back.sv @@
// Back end: takes jobs from the queue and emits their bytes one per
// transaction from a held output register. Depends on b64d_pkg, b64d_if.
`default_nettype none

module b64d_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire b64d_pkg::b64d_job_t  job,
	input  wire logic                 job_valid,
	output logic                      pop,
	b64d_out_if.source                out_ch
);

	b64d_pkg::b64d_job_t cur_q;
	logic [1:0]          idx_q;
	logic                busy_q;
	logic                last;
	logic                take;

	assign last = (idx_q == (cur_q.count - 2'd1));
	assign take = busy_q && out_ch.ready;
	assign pop  = !busy_q || (take && last);

	assign out_ch.valid        = busy_q;
	assign out_ch.end_of_data  = cur_q.fin && last;
	assign out_ch.length_error = cur_q.err;

	always_comb begin
		case (idx_q)
			2'd0:    out_ch.data_byte = cur_q.word[23:16];
			2'd1:    out_ch.data_byte = cur_q.word[15:8];
			default: out_ch.data_byte = cur_q.word[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && job_valid) begin
			cur_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= job_valid;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for base64_stream_decoder_core: drives base64 text and random characters, predicts the decoded
// bytes and compares every output transaction with the oldest predicted byte.
// Depends on b64d_pkg, b64d_if and the decoder RTL.
`timescale 1ns / 1ps

typedef struct {
	logic [7:0] data;
	logic       eod;
	logic       err;
} decoded_byte_t;

class base64_byte_tracker;
	decoded_byte_t expected_bytes[$];
	logic [17:0]   sextets;
	logic [1:0]    position;
	logic          third_pad;
	int            failures;

	function new();
		sextets = '0;
		position = '0;
		third_pad = 1'b0;
		failures = 0;
	endfunction

	function logic [5:0] sextet_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return 6'(c - "A");
		if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
		if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
		if (c == "+") return 6'd62;
		if (c == "/") return 6'd63;
		return 6'd0;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	function void push_byte(input logic [7:0] d, input logic e, input logic r);
		decoded_byte_t b;
		b.data = d;
		b.eod = e;
		b.err = r;
		expected_bytes.push_back(b);
	endfunction

	function void note_char(input logic [7:0] c, input logic fin);
		logic [5:0]  v;
		logic        pad;
		logic [23:0] word;
		int          pads;
		int          n;
		v = sextet_value(c);
		pad = (c == b64d_pkg::PAD_CHAR);
		if (position != b64d_pkg::QUARTET_LAST) begin
			if (fin) begin
				sextets = '0;
				position = '0;
				third_pad = 1'b0;
				push_byte(8'h00, 1'b1, 1'b1);
				return;
			end
			if (position == b64d_pkg::THIRD_POS)
				third_pad = pad;
			sextets = {sextets[11:0], v};
			position = position + 2'd1;
		end else begin
			word = {sextets, v};
			pads = int'(third_pad) + int'(pad);
			if (!fin)
				n = 3;
			else if (pads == 2)
				n = 1;
			else if (pads == 1)
				n = 2;
			else
				n = 3;
			for (int k = 0; k < n; k++)
				push_byte(word[23 - 8 * k -: 8], fin && (k == n - 1), 1'b0);
			sextets = '0;
			position = '0;
			third_pad = 1'b0;
		end
	endfunction

	task report(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		failures++;
	endtask

	task check_byte(input logic [7:0] d, input logic e, input logic r);
		decoded_byte_t x;
		if (expected_bytes.size() == 0) begin
			report($sformatf("unexpected byte %02h eod %b err %b", d, e, r));
			return;
		end
		x = expected_bytes.pop_front();
		if (d !== x.data)
			report($sformatf("data_byte %02h, want %02h", d, x.data));
		if (e !== x.eod)
			report($sformatf("end_of_data %b, want %b", e, x.eod));
		if (r !== x.err)
			report($sformatf("length_error %b, want %b", r, x.err));
	endtask
endclass

module testbench;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 88;
	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   chars_sent;
	int   quiet_cycles;

	b64d_in_if  in_ch();
	b64d_out_if out_ch();

	base64_byte_tracker tracker;

	base64_stream_decoder_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_byte(out_ch.data_byte, out_ch.end_of_data, out_ch.length_error);
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task send_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.char_code <= 8'($urandom_range(255));
			in_ch.is_final <= 1'($urandom_range(1));
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_code <= c;
		in_ch.is_final <= fin;
		do
			@(posedge clk);
		while (!in_ch.ready);
		tracker.note_char(c, fin);
		chars_sent++;
	endtask

	task send_text(input string s, input bit fin_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], fin_last && (i == s.len() - 1));
	endtask

	function logic [7:0] alphabet_char();
		if ($urandom_range(19) == 0)
			return b64d_pkg::PAD_CHAR;
		return ALPHABET[$urandom_range(63)];
	endfunction

	task send_wellformed();
		int          quartets;
		int          pad_mode;
		int          total;
		int          cut;
		logic [7:0]  text[$];
		quartets = $urandom_range(1, 4);
		pad_mode = $urandom_range(3);
		for (int q = 0; q < quartets; q++)
			for (int k = 0; k < 4; k++)
				text.push_back(alphabet_char());
		total = text.size();
		if (pad_mode == 1 || pad_mode == 2)
			text[total - 1] = b64d_pkg::PAD_CHAR;
		if (pad_mode == 2 || pad_mode == 3)
			text[total - 2] = b64d_pkg::PAD_CHAR;
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(1, 3);
			repeat (cut) void'(text.pop_back());
		end
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
	endtask

	task send_noise();
		repeat ($urandom_range(1, 8))
			send_char(8'($urandom_range(255)), $urandom_range(5) == 0);
	endtask

	task run_phase(input int idle_pct, input int stall_pct);
		int start;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = chars_sent;
		while (chars_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(99) < 80)
				send_wellformed();
			else
				send_noise();
		end
	endtask

	initial begin
		tracker = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		chars_sent = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.char_code <= 8'h00;
		in_ch.is_final <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("////", 1'b1);
		send_text("TQ==", 1'b1);
		send_text("TWE=", 1'b1);
		send_text("Zz==", 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(b64d_pkg::PAD_CHAR, 1'b1);
		send_text("A=", 1'b1);
		send_text("9", 1'b1);

		run_phase(0, 0);
		run_phase(77, 0);
		run_phase(0, 77);
		run_phase(25, 25);

		in_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
design/b64d_pkg.sv
design/b64d_if.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_core.sv
tb/sv/testbench.sv
